// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbc_pkg.sv =====
package sbc_pkg;

  localparam int MAX_BUCKETS = 16;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int NB_W        = BKT_W + 1;
  localparam int CNT_W       = 21;
  localparam logic [CNT_W-1:0] MAX_BATCH = CNT_W'(1048576);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;
  localparam logic KIND_PLACE    = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [BKT_W-1:0]   table_index;
    logic signed [31:0] value;
    logic               last_value;
  } sbc_in_t;

  typedef struct packed {
    logic             kind;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] amount;
    logic             final_result;
  } sbc_out_t;

  // Classified value on its way from front to back.
  typedef struct packed {
    logic [BKT_W-1:0] bucket;
    logic             last;
  } sbc_class_t;

  // Clamp the register to 1..MAX_BUCKETS.
  function automatic logic [NB_W-1:0] active_count(input logic [4:0] bu);
    logic [NB_W-1:0] n;
    if (bu == 5'd0) begin
      n = NB_W'(1);
    end else if (bu > 5'(MAX_BUCKETS)) begin
      n = NB_W'(MAX_BUCKETS);
    end else begin
      n = NB_W'(bu);
    end
    return n;
  endfunction

endpackage

// ===== rtl/sbc_front.sv =====
module sbc_front
  import sbc_pkg::*;
(
  input  logic             clk,
  input  logic             in_valid,
  output logic             in_ready,
  input  sbc_in_t          in_data,
  input  logic [NB_W-1:0]  n_active,
  input  logic             q_full,
  output logic             q_push,
  output sbc_class_t       q_item
);

  logic signed [31:0] split_r [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] hit;
  logic [BKT_W-1:0] bkt;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (in_data.mode == MODE_CLASSIFY);

  // Load the splitter entry; no reset, entries are undefined until loaded.
  always_ff @(posedge clk) begin
    if (accept && (in_data.mode == MODE_LOAD)) begin
      split_r[in_data.table_index] <= in_data.value;
    end
  end

  // Compare against every active splitter in parallel, take the first hit.
  always_comb begin
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      hit[i] = (NB_W'(i) < n_active) && (in_data.value <= split_r[i]);
    end
    bkt = BKT_W'(n_active - NB_W'(1));
    for (int i = MAX_BUCKETS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        bkt = BKT_W'(i);
      end
    end
  end

  assign q_item.bucket = bkt;
  assign q_item.last   = in_data.last_value;

endmodule

// ===== rtl/sbc_fifo.sv =====
`include "assert_macros.svh"

module sbc_fifo
  import sbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sbc_class_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output sbc_class_t pop_item
);

  sbc_class_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic [QCNT_W-1:0]  count_nxt;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  `SBC_ASSERT_NOW(a_fifo_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue over depth")
  `SBC_ASSERT_NEXT(a_fifo_grow, push && !pop, count_r == $past(count_r) + QCNT_W'(1), "queue lost a push")

endmodule

// ===== rtl/sbc_back.sv =====
`include "assert_macros.svh"

module sbc_back
  import sbc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [NB_W-1:0] n_active,
  input  logic            q_valid,
  input  sbc_class_t      q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output sbc_out_t        out_data
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_RPT = 1'b1;

  logic             state_r;
  logic [BKT_W-1:0] rpt_idx_r;
  logic [CNT_W-1:0] counts_r [MAX_BUCKETS];
  logic             out_valid_r;
  sbc_out_t         out_data_r;

  logic             advance;
  logic             load_rpt;
  logic             rpt_final;
  logic [BKT_W-1:0] rd_addr;
  logic [CNT_W-1:0] cnt_rd;

  assign advance   = !out_valid_r || out_ready;
  assign q_pop     = (state_r == ST_RUN) && q_valid && advance;
  assign load_rpt  = (state_r == ST_RPT) && advance;
  assign rpt_final = (NB_W'(rpt_idx_r) == n_active - NB_W'(1));
  assign rd_addr   = (state_r == ST_RPT) ? rpt_idx_r : q_item.bucket;
  assign cnt_rd    = counts_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      rpt_idx_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (q_pop || load_rpt) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        // Slot is the count before this value; saturate at the batch limit.
        if (cnt_rd < MAX_BATCH) begin
          counts_r[q_item.bucket] <= cnt_rd + CNT_W'(1);
        end
        if (q_item.last) begin
          state_r   <= ST_RPT;
          rpt_idx_r <= '0;
        end
      end
      if (load_rpt) begin
        if (rpt_final) begin
          state_r <= ST_RUN;
          for (int i = 0; i < MAX_BUCKETS; i++) begin
            counts_r[i] <= '0;
          end
        end else begin
          rpt_idx_r <= rpt_idx_r + BKT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.kind         <= KIND_PLACE;
      out_data_r.bucket       <= q_item.bucket;
      out_data_r.amount       <= cnt_rd;
      out_data_r.final_result <= !q_item.last;
    end else if (load_rpt) begin
      out_data_r.kind         <= KIND_REPORT;
      out_data_r.bucket       <= rpt_idx_r;
      out_data_r.amount       <= cnt_rd;
      out_data_r.final_result <= rpt_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBC_ASSERT_NOW(a_back_sat, q_pop || load_rpt, cnt_rd <= MAX_BATCH, "count past batch limit")
  `SBC_ASSERT_NEXT(a_back_clear, load_rpt && rpt_final,
                   (counts_r[0] == '0) && (state_r == ST_RUN), "counts kept after report")

endmodule

// ===== rtl/splitter_bucket_classifier.sv =====
// Channel   Direction  Handshake              Moves
// in_       input      in_valid / in_ready    one request: splitter load or value to classify
// out_      output     out_valid / out_ready  one placement or one bucket count report
// cfg (APB) input      psel/penable/pready    buckets_in_use at byte address 0
//
// A request is taken while the queue has room; the front classifies a value in the cycle
// it is taken (sixteen parallel splitter compares) and queues it, four deep.
// While out_ready does not stall it, the back emits one placement per cycle through its
// single count read port; a batch-end value then holds the back for one count report per
// active bucket (buckets_in_use clamped to 1..16), one report per cycle while not stalled.
// A splitter load produces nothing and does not enter the queue.
// Reset (rst_n, synchronous) clears the queue, all bucket counts and the output valid flag,
// and sets buckets_in_use to 16; the splitter table keeps no reset value.
// Either side may stall: the queue and the output register decouple front and back.
module splitter_bucket_classifier
  import sbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sbc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sbc_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_BUCKETS_IN_USE = 1'b0;

  logic [4:0]      buckets_in_use_r;
  logic [NB_W-1:0] n_active;
  logic            cfg_write;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  sbc_class_t q_in;
  sbc_class_t q_out;

  // Configuration: write on the access cycle, read back combinationally.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buckets_in_use_r <= 5'd16;
    end else if (cfg_write && (paddr[2] == REG_BUCKETS_IN_USE)) begin
      buckets_in_use_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUCKETS_IN_USE) ? {27'd0, buckets_in_use_r} : '0;

  // Zero acts as one active bucket; anything above the table size acts as all of it.
  assign n_active = active_count(buckets_in_use_r);

  sbc_front u_front (
    .clk      (clk),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .n_active (n_active),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  sbc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_out)
  );

  sbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_active  (n_active),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          QUIET_CYCLES = 12;
  localparam int          LONG_STALL   = 300;
  localparam int          PRINT_CAP    = 40;
  localparam logic [2:0]  BUCKETS_ADDR = 3'd0;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  sbc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sbc_out_t    out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  splitter_bucket_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Requests waiting for the driver, and results the block still owes us.
  sbc_in_t  requests_pending[$];
  sbc_out_t results_due[$];

  // Shadow state of the block, advanced once per accepted request.
  logic signed [31:0] splitter_shadow[MAX_BUCKETS];
  logic [CNT_W-1:0]   bucket_tally[MAX_BUCKETS];
  logic [4:0]         buckets_reg = 5'd16;

  // Copy of the splitter table as the stimulus sees it; used only to aim
  // data values at splitter boundaries.
  logic signed [31:0] aimed_split[MAX_BUCKETS];

  int          fail_count  = 0;
  int unsigned cycle_count = 0;
  int          batch_left  = 0;

  // Sender pacing and pressure controls (written from the stimulus block).
  logic tx_steady = 1'b0;
  logic stall_arm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  // Predict the results of one accepted request and advance the shadow state.
  function automatic void classify_request(input sbc_in_t req);
    int unsigned      n;
    int unsigned      b;
    bit               found;
    logic [CNT_W-1:0] slot;
    sbc_out_t         r;
    if (req.mode == MODE_LOAD) begin
      splitter_shadow[req.table_index] = req.value;
      return;
    end
    // Clamp the register the same way the block does: zero acts as one,
    // anything past the table size acts as the full table.
    if (buckets_reg == 5'd0) begin
      n = 1;
    end else if (buckets_reg > 5'(MAX_BUCKETS)) begin
      n = MAX_BUCKETS;
    end else begin
      n = buckets_reg;
    end
    b = n - 1;
    found = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && ($signed(req.value) <= $signed(splitter_shadow[i]))) begin
        b = i;
        found = 1'b1;
      end
    end
    // Saturate the tally; the slot then reads as the batch limit.
    slot = bucket_tally[b];
    if (slot < MAX_BATCH) begin
      bucket_tally[b] = slot + 1'b1;
    end else begin
      slot = MAX_BATCH;
    end
    r.kind         = KIND_PLACE;
    r.bucket       = BKT_W'(b);
    r.amount       = slot;
    r.final_result = !req.last_value;
    results_due.push_back(r);
    if (req.last_value) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.kind         = KIND_REPORT;
        r.bucket       = BKT_W'(i);
        r.amount       = bucket_tally[i];
        r.final_result = (i == n - 1);
        results_due.push_back(r);
      end
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        bucket_tally[i] = '0;
      end
    end
  endfunction

  function automatic void push_request(input logic mode, input logic [BKT_W-1:0] idx,
                                       input logic signed [31:0] v, input logic last);
    sbc_in_t req;
    req.mode        = mode;
    req.table_index = idx;
    req.value       = v;
    req.last_value  = last;
    if (mode == MODE_LOAD) begin
      aimed_split[idx] = v;
    end
    requests_pending.push_back(req);
  endfunction

  // Often land on or next to a splitter so the <= compare is exercised at
  // its edges; the rest are extremes or fully random words.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] s;
    s = aimed_split[$urandom_range(0, MAX_BUCKETS - 1)];
    case ($urandom_range(0, 7))
      0: return s;
      1: return s + 32'sd1;
      2: return s - 32'sd1;
      3: return 32'sh8000_0000;
      4: return 32'sh7fff_ffff;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // Queue one random request: mostly values inside batches of random length,
  // now and then a splitter reload (with a junk last flag) as noise.
  function automatic void queue_random_item();
    if ($urandom_range(0, 99) < 8) begin
      push_request(MODE_LOAD, BKT_W'($urandom), $signed(32'($urandom)), 1'($urandom));
    end else begin
      push_request(MODE_CLASSIFY, BKT_W'($urandom), pick_value(), batch_left == 0);
      if (batch_left == 0) begin
        batch_left = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 14);
      end else begin
        batch_left--;
      end
    end
  endfunction

  // Hold until every request is taken and every result is back, then give
  // the block time to finish a trailing splitter load.
  task automatic wait_quiet();
    do @(posedge clk);
    while (in_valid || requests_pending.size() != 0 || results_due.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Write buckets_in_use through the register port, then read it back.
  // Upper data bits are random; only the low five bits land in the register.
  task automatic write_buckets(input logic [4:0] v);
    logic [31:0] word;
    word = $urandom;
    word[4:0] = v;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUCKETS_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write lands at this edge.
    buckets_reg = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {27'd0, v}) begin
      flag_mismatch($sformatf("buckets_in_use read %0h, wrote %0d", prdata, v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: predict on every accepted request, hold the request while it is
  // stalled, otherwise offer the next one when the current burst allows.
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        classify_request(in_data);
      end
      if (in_valid && !in_ready) begin
        // hold: valid stays up with the same payload
      end else if (requests_pending.size() != 0 && (tx_steady || gap_left == 0)) begin
        in_valid <= 1'b1;
        in_data  <= requests_pending.pop_front();
        if (!tx_steady) begin
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= $urandom_range(0, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end
      end
    end
  end

  // Receiver: an 8-bit ready pattern, redrawn each lap and sometimes all
  // ones; a toggle of stall_arm starts a long hold counted here.
  logic [7:0] ready_pattern = 8'hff;
  logic [2:0] ready_phase   = '0;
  logic       stall_seen    = 1'b0;
  int         stall_left    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_seen <= stall_arm;
      if (stall_arm != stall_seen) begin
        stall_left <= LONG_STALL;
        out_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready   <= ready_pattern[ready_phase];
        ready_phase <= ready_phase + 1'b1;
        if (ready_phase == 3'd7) begin
          ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        end
      end
    end
  end

  // Monitor: every accepted result must match the oldest expectation.
  always @(posedge clk) begin : watch_results
    sbc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d bucket %0d amount %0d",
                                out_data.kind, out_data.bucket, out_data.amount));
      end else begin
        want = results_due.pop_front();
        if (out_data.kind !== want.kind || out_data.bucket !== want.bucket ||
            out_data.amount !== want.amount || out_data.final_result !== want.final_result) begin
          flag_mismatch($sformatf("got k%0d b%0d a%0d f%0d, want k%0d b%0d a%0d f%0d",
                                  out_data.kind, out_data.bucket, out_data.amount,
                                  out_data.final_result, want.kind, want.bucket,
                                  want.amount, want.final_result));
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Splitter table for the directed part: extremes, out-of-order entries,
  // and nothing at the top of the range so the largest value falls through
  // to the last bucket.
  logic signed [31:0] seed_split[MAX_BUCKETS] = '{
    32'sh8000_0000, -32'sd1, 32'sd0, 32'sd100, 32'sd50, 32'sd1000, 32'sd2000, -32'sd5,
    32'sd4000, 32'sd8000, 32'sd16000, 32'sd32000, 32'sd64000, 32'sd128000,
    32'sh7fff_fffe, 32'sd300000
  };
  logic [4:0] phase_buckets[8] = '{5'd5, 5'd1, 5'd16, 5'd0, 5'd20, 5'd31, 5'd9, 5'd3};

  initial begin
    int n_items;
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      splitter_shadow[i] = '0;
      bucket_tally[i]    = '0;
      aimed_split[i]     = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: load every splitter before any value is classified, so no
    // compare ever reads an entry that was never written. The first load
    // carries a stray last flag, which must be ignored.
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      push_request(MODE_LOAD, BKT_W'(i), seed_split[i], i == 0);
    end
    push_request(MODE_CLASSIFY, 4'hf, 32'sh8000_0000, 1'b0); // smallest value
    push_request(MODE_CLASSIFY, 4'h0, 32'sh7fff_ffff, 1'b0); // past every splitter
    push_request(MODE_CLASSIFY, 4'h5, -32'sd1, 1'b0);        // equal to a splitter
    push_request(MODE_CLASSIFY, 4'ha, 32'sd101, 1'b0);       // just above one
    push_request(MODE_CLASSIFY, 4'h3, 32'sh7fff_fffe, 1'b0);
    push_request(MODE_CLASSIFY, 4'hc, 32'sh7fff_ffff, 1'b0); // same bucket again
    push_request(MODE_CLASSIFY, 4'h7, 32'sd75, 1'b1);        // batch end, full report
    wait_quiet();

    // Random phases, one register setting each, including zero and values
    // past the table size. Batches run across phase boundaries, so tallies
    // survive a change of the bucket count.
    for (int ph = 0; ph < 8; ph++) begin
      write_buckets(phase_buckets[ph]);
      n_items = $urandom_range(45, 55);
      if (ph == 2) begin
        // Back-pressure: stop the receiver for a long stretch while the
        // sender keeps offering, so the block fills and stalls its input.
        tx_steady <= 1'b1;
        stall_arm <= ~stall_arm;
        for (int k = 0; k < 40; k++) begin
          queue_random_item();
        end
        wait_quiet();
        tx_steady <= 1'b0;
        n_items = n_items - 40;
      end
      for (int k = 0; k < n_items; k++) begin
        queue_random_item();
        // Pause the sender mid-phase until the block has drained.
        if (ph == 4 && k == n_items / 2) begin
          wait_quiet();
        end
      end
      wait_quiet();
    end

    repeat (QUIET_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbc_pkg.sv
rtl/sbc_front.sv
rtl/sbc_fifo.sv
rtl/sbc_back.sv
rtl/splitter_bucket_classifier.sv
tb/sv/testbench.sv
